/* rtl/core/rqps_pkg.sv */
// Shared types and constants of the R-tree quadratic seed picker.
`default_nettype none

package rqps_pkg;

	localparam int MaxEntries  = 16;
	localparam int CoordBits   = 16;
	localparam int IdxBits     = $clog2(MaxEntries);
	localparam int CntBits     = $clog2(MaxEntries + 1);
	localparam int AreaBits    = 2 * CoordBits;
	localparam int WasteBits   = AreaBits + 2;
	localparam int DeadBits    = AreaBits + 1;
	localparam int RectBits    = 4 * CoordBits;
	localparam int DrainCycles = 4;
	localparam int DrainBits   = 2;

	localparam logic [1:0] StatusOk      = 2'd0;
	localparam logic [1:0] StatusFew     = 2'd1;
	localparam logic [1:0] StatusDropped = 2'd2;

	typedef struct packed {
		logic signed [CoordBits-1:0] x_low;
		logic signed [CoordBits-1:0] y_low;
		logic signed [CoordBits-1:0] x_high;
		logic signed [CoordBits-1:0] y_high;
	} rect_t;

	typedef struct packed {
		logic               prime;
		logic [IdxBits-1:0] first;
		logic [IdxBits-1:0] second;
	} tag_t;

endpackage

`default_nettype wire

/* rtl/core/rqps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rqps_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/rqps_waste.sv */
// Dead-area pipeline: extents, areas, then merged area minus both areas.
`default_nettype none

module rqps_waste (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             vld_s1,
	input  wire rqps_pkg::tag_t                   tag_s1,
	input  wire rqps_pkg::rect_t                  rect_a_s1,
	input  wire rqps_pkg::rect_t                  rect_b_s1,
	output logic                                  vld_s4,
	output rqps_pkg::tag_t                        tag_s4,
	output logic signed [rqps_pkg::WasteBits-1:0] waste_s4
);

	function automatic logic [rqps_pkg::CoordBits-1:0] extent(
		input logic signed [rqps_pkg::CoordBits-1:0] lo,
		input logic signed [rqps_pkg::CoordBits-1:0] hi
	);
		logic [rqps_pkg::CoordBits:0] d;
		d = {hi[rqps_pkg::CoordBits-1], hi} - {lo[rqps_pkg::CoordBits-1], lo};
		return (hi < lo) ? '0 : d[rqps_pkg::CoordBits-1:0];
	endfunction

	logic signed [rqps_pkg::CoordBits-1:0] mxl, myl, mxh, myh;

	logic                             vld_s2, vld_s3;
	rqps_pkg::tag_t                   tag_s2, tag_s3;
	logic [rqps_pkg::CoordBits-1:0]   emx_s2, emy_s2, eax_s2, eay_s2, ebx_s2, eby_s2;
	logic [rqps_pkg::AreaBits-1:0]    am_s3, aa_s3, ab_s3;

	always_comb begin
		mxl = (rect_a_s1.x_low < rect_b_s1.x_low) ? rect_a_s1.x_low : rect_b_s1.x_low;
		myl = (rect_a_s1.y_low < rect_b_s1.y_low) ? rect_a_s1.y_low : rect_b_s1.y_low;
		mxh = (rect_a_s1.x_high < rect_b_s1.x_high) ? rect_b_s1.x_high : rect_a_s1.x_high;
		myh = (rect_a_s1.y_high < rect_b_s1.y_high) ? rect_b_s1.y_high : rect_a_s1.y_high;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2   <= tag_s1;
		emx_s2   <= extent(mxl, mxh);
		emy_s2   <= extent(myl, myh);
		eax_s2   <= extent(rect_a_s1.x_low, rect_a_s1.x_high);
		eay_s2   <= extent(rect_a_s1.y_low, rect_a_s1.y_high);
		ebx_s2   <= extent(rect_b_s1.x_low, rect_b_s1.x_high);
		eby_s2   <= extent(rect_b_s1.y_low, rect_b_s1.y_high);

		tag_s3   <= tag_s2;
		am_s3    <= rqps_pkg::AreaBits'(emx_s2) * rqps_pkg::AreaBits'(emy_s2);
		aa_s3    <= rqps_pkg::AreaBits'(eax_s2) * rqps_pkg::AreaBits'(eay_s2);
		ab_s3    <= rqps_pkg::AreaBits'(ebx_s2) * rqps_pkg::AreaBits'(eby_s2);

		tag_s4   <= tag_s3;
		waste_s4 <= $signed({2'b00, am_s3}) - $signed({2'b00, aa_s3})
			- $signed({2'b00, ab_s3});
	end

endmodule

`default_nettype wire

/* rtl/core/rtree_quadratic_pick_seeds_unit.sv */
// Top level of the R-tree quadratic split seed picker.
//
// Input channel: one rectangle per word (x_low, y_low, x_high, y_high,
// last_entry), taken one per cycle while the block is loading. Up to 16
// rectangles are stored; later ones are dropped and flagged in status.
// The word with last_entry set closes the node; in_stall then stays high
// until the result has been placed in the output register.
// Search: two copies of the rectangle RAM are read at i and j, one ordered
// pair per cycle, feeding a four-stage dead-area pipeline. With n stored
// rectangles the search issues n*n+1 pairs (the first is the starting pair
// (0,1)). Fewer than two entries skip the search.
// Output channel: one result word per node from an output register; a new
// node may load while that word is still stalled, but the next result waits
// until it has been taken.
// Reset clears the entry count, overflow flag, state and output valid.
`default_nettype none

module rtree_quadratic_pick_seeds_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [rqps_pkg::CoordBits-1:0] x_low,
	input  wire logic signed [rqps_pkg::CoordBits-1:0] y_low,
	input  wire logic signed [rqps_pkg::CoordBits-1:0] x_high,
	input  wire logic signed [rqps_pkg::CoordBits-1:0] y_high,
	input  wire logic                                  last_entry,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [rqps_pkg::IdxBits-1:0]               first_seed,
	output logic [rqps_pkg::IdxBits-1:0]               second_seed,
	output logic signed [rqps_pkg::DeadBits-1:0]       dead_area,
	output logic [1:0]                                 status
);

	localparam logic [1:0] StLoad   = 2'd0;
	localparam logic [1:0] StSearch = 2'd1;
	localparam logic [1:0] StDrain  = 2'd2;
	localparam logic [1:0] StFinish = 2'd3;

	logic [1:0]                     state_q;
	logic [rqps_pkg::CntBits-1:0]   cnt_q, n_new;
	logic                           ovf_q, few_q, init_q;
	logic [rqps_pkg::IdxBits-1:0]   last_idx_q, i_q, j_q, rd_a, rd_b;
	logic [rqps_pkg::DrainBits-1:0] drn_q;

	logic in_acc, store_en, issue, out_free, finish;

	rqps_pkg::rect_t                        wr_rect, rect_a_s1, rect_b_s1;
	logic                                   vld_s1, vld_s4;
	rqps_pkg::tag_t                         tag_s1, tag_s4;
	logic signed [rqps_pkg::WasteBits-1:0]  waste_s4, best_w_q;
	logic [rqps_pkg::IdxBits-1:0]           best_i_q, best_j_q;

	logic                                   out_valid_q;

	assign in_stall = (state_q != StLoad);
	assign in_acc   = in_valid && !in_stall;
	assign store_en = in_acc && (cnt_q < rqps_pkg::CntBits'(rqps_pkg::MaxEntries));
	assign n_new    = store_en ? cnt_q + rqps_pkg::CntBits'(1) : cnt_q;
	assign issue    = (state_q == StSearch);
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == StFinish) && out_free;

	assign wr_rect = '{x_low: x_low, y_low: y_low, x_high: x_high, y_high: y_high};
	assign rd_a    = init_q ? '0 : i_q;
	assign rd_b    = init_q ? rqps_pkg::IdxBits'(1) : j_q;

	// Writes happen only while loading; read data is used only while searching.
	rqps_ram #(.Width(rqps_pkg::RectBits), .Depth(rqps_pkg::MaxEntries)) u_ram_a (
		.clk   (clk),
		.we    (store_en),
		.waddr (cnt_q[rqps_pkg::IdxBits-1:0]),
		.wdata (wr_rect),
		.raddr (rd_a),
		.rdata (rect_a_s1)
	);

	rqps_ram #(.Width(rqps_pkg::RectBits), .Depth(rqps_pkg::MaxEntries)) u_ram_b (
		.clk   (clk),
		.we    (store_en),
		.waddr (cnt_q[rqps_pkg::IdxBits-1:0]),
		.wdata (wr_rect),
		.raddr (rd_b),
		.rdata (rect_b_s1)
	);

	rqps_waste u_waste (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s1    (vld_s1),
		.tag_s1    (tag_s1),
		.rect_a_s1 (rect_a_s1),
		.rect_b_s1 (rect_b_s1),
		.vld_s4    (vld_s4),
		.tag_s4    (tag_s4),
		.waste_s4  (waste_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StLoad;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			few_q      <= 1'b0;
			init_q     <= 1'b0;
			last_idx_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			drn_q      <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= issue;
			case (state_q)
				StLoad: begin
					if (in_acc) begin
						cnt_q <= n_new;
						ovf_q <= ovf_q || !store_en;
						if (last_entry) begin
							few_q      <= (n_new < rqps_pkg::CntBits'(2));
							last_idx_q <= rqps_pkg::IdxBits'(n_new - rqps_pkg::CntBits'(1));
							init_q     <= 1'b1;
							i_q        <= '0;
							j_q        <= '0;
							state_q    <= (n_new < rqps_pkg::CntBits'(2)) ? StFinish : StSearch;
						end
					end
				end
				StSearch: begin
					if (init_q) begin
						init_q <= 1'b0;
					end else if (j_q == last_idx_q) begin
						j_q <= '0;
						if (i_q == last_idx_q) begin
							drn_q   <= '0;
							state_q <= StDrain;
						end else begin
							i_q <= i_q + rqps_pkg::IdxBits'(1);
						end
					end else begin
						j_q <= j_q + rqps_pkg::IdxBits'(1);
					end
				end
				StDrain: begin
					drn_q <= drn_q + rqps_pkg::DrainBits'(1);
					if (drn_q == rqps_pkg::DrainBits'(rqps_pkg::DrainCycles - 1)) begin
						state_q <= StFinish;
					end
				end
				StFinish: begin
					if (out_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= StLoad;
					end
				end
				default: begin
					state_q <= StLoad;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= '{prime: init_q, first: rd_a, second: rd_b};
		if (vld_s4 && (tag_s4.prime || (waste_s4 > best_w_q))) begin
			best_w_q <= waste_s4;
			best_i_q <= tag_s4.first;
			best_j_q <= tag_s4.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (few_q) begin
				first_seed  <= '0;
				second_seed <= rqps_pkg::IdxBits'(1);
				dead_area   <= '0;
				status      <= rqps_pkg::StatusFew;
			end else begin
				first_seed  <= best_i_q;
				second_seed <= best_j_q;
				dead_area   <= best_w_q[rqps_pkg::DeadBits-1:0];
				status      <= ovf_q ? rqps_pkg::StatusDropped : rqps_pkg::StatusOk;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/rqps_checker.sv */
// Port-level assertions for the seed picker, bound to the top level.
`default_nettype none

module rqps_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_stall,
	input wire logic                                  last_entry,
	input wire logic                                  out_valid,
	input wire logic                                  out_stall,
	input wire logic [rqps_pkg::IdxBits-1:0]          first_seed,
	input wire logic [rqps_pkg::IdxBits-1:0]          second_seed,
	input wire logic signed [rqps_pkg::DeadBits-1:0]  dead_area,
	input wire logic [1:0]                            status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(first_seed) && $stable(second_seed)
			&& $stable(dead_area) && $stable(status))
		else $error("result word changed while stalled");

	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_entry |=> in_stall)
		else $error("input taken straight after the closing word");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_few_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rqps_pkg::StatusFew |->
			first_seed == '0 && second_seed == rqps_pkg::IdxBits'(1) && dead_area == '0)
		else $error("short node result is not the starting pair");

endmodule

bind rtree_quadratic_pick_seeds_unit rqps_checker u_rqps_checker (.*);

`default_nettype wire
